>>> rtl/lqpi_pkg.sv
`timescale 1ns / 1ps
// Package for the luma quarter-pel interpolator: widths, register indexes,
// filter tap and low-pass weight functions. No dependencies.
package lqpi_pkg;

  localparam int MaxWidthDefault = 64;
  localparam int MaxHeight       = 64;
  localparam int StoreRows       = 5;
  localparam int DimW            = 7;
  localparam int PixW            = 8;
  localparam int VsumW           = 18;
  localparam int HsumW           = 26;
  localparam int RoundOfs        = 8192;
  localparam int RoundShift      = 14;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_BLOCK_WIDTH  = 2'd0,
    REG_BLOCK_HEIGHT = 2'd1,
    REG_QPEL_X       = 2'd2,
    REG_QPEL_Y       = 2'd3
  } reg_index_t;

  typedef logic signed [8:0] coef_t;

  // Six-tap quarter-pel filter coefficients, selected by fraction and tap.
  function automatic coef_t tap_coef(input logic [1:0] frac, input logic [2:0] idx);
    coef_t c;
    c = '0;
    case (frac)
      2'd0: case (idx)
        3'd2:    c = 9'sd128;
        default: c = 9'sd0;
      endcase
      2'd1: case (idx)
        3'd0:    c = 9'sd3;
        3'd1:    c = -9'sd15;
        3'd2:    c = 9'sd111;
        3'd3:    c = 9'sd37;
        3'd4:    c = -9'sd10;
        3'd5:    c = 9'sd2;
        default: c = 9'sd0;
      endcase
      2'd2: case (idx)
        3'd0:    c = 9'sd3;
        3'd1:    c = -9'sd17;
        3'd2:    c = 9'sd78;
        3'd3:    c = 9'sd78;
        3'd4:    c = -9'sd17;
        3'd5:    c = 9'sd3;
        default: c = 9'sd0;
      endcase
      default: case (idx)
        3'd0:    c = 9'sd2;
        3'd1:    c = -9'sd10;
        3'd2:    c = 9'sd37;
        3'd3:    c = 9'sd111;
        3'd4:    c = -9'sd15;
        3'd5:    c = 9'sd3;
        default: c = 9'sd0;
      endcase
    endcase
    return c;
  endfunction

  // Weight of the 4x4 low-pass kernel: 0 at corners, 1 on edges, 2 inside.
  function automatic logic [1:0] lp_weight(input logic [1:0] i, input logic [1:0] j);
    logic [1:0] wi;
    logic [1:0] wj;
    wi = (i == 2'd1 || i == 2'd2) ? 2'd1 : 2'd0;
    wj = (j == 2'd1 || j == 2'd2) ? 2'd1 : 2'd0;
    return wi + wj;
  endfunction

endpackage

>>> rtl/luma_quarter_pel_interpolator.sv
`timescale 1ns / 1ps
// Luma quarter-pel interpolator top level: window counters, five-row line
// store, vertical and horizontal 6-tap filters and low-pass path. Uses lqpi_pkg.
//
//  channel  | signals                                      | beat
//  ---------+----------------------------------------------+--------------------
//  input    | in_valid, in_ready, ref_pixel, window_start  | one window pixel
//  output   | out_valid, out_ready, pred_pixel, block_last | one predicted pixel
//  config   | cfg_we, cfg_index, cfg_data                  | one register write
//
// One input beat can be taken every cycle while the output is not stalled.
// A pixel passes the line store read into the stage 1 registers, the vertical
// filter into the tap lines and the horizontal filter into the output register.
// All stages advance together whenever the output register is empty or its
// beat is taken, so a stalled output holds the input off. Reset clears the
// counters, taps and valid bits; the line store is not cleared.
module luma_quarter_pel_interpolator
  import lqpi_pkg::*;
#(
  parameter int MAX_WIDTH = MaxWidthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PixW-1:0]      ref_pixel,
  input  logic                 window_start,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PixW-1:0]      pred_pixel,
  output logic                 block_last,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [DimW-1:0]      cfg_data
);

  localparam int Depth = MAX_WIDTH + 5;
  localparam int ColW  = $clog2(Depth);

  // Configuration registers.
  logic [DimW-1:0] block_width;
  logic [DimW-1:0] block_height;
  logic [1:0]      qpel_x;
  logic [1:0]      qpel_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_width  <= DimW'(8);
      block_height <= DimW'(8);
      qpel_x       <= 2'd0;
      qpel_y       <= 2'd0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_BLOCK_WIDTH:  block_width  <= cfg_data;
        REG_BLOCK_HEIGHT: block_height <= cfg_data;
        REG_QPEL_X:       qpel_x       <= cfg_data[1:0];
        REG_QPEL_Y:       qpel_y       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Clamped block dimensions.
  logic [7:0] w_eff;
  logic [7:0] h_eff;

  always_comb begin
    if (block_width == '0) begin
      w_eff = 8'd1;
    end else if ({1'b0, block_width} > 8'(MAX_WIDTH)) begin
      w_eff = 8'(MAX_WIDTH);
    end else begin
      w_eff = {1'b0, block_width};
    end
    if (block_height == '0) begin
      h_eff = 8'd1;
    end else if ({1'b0, block_height} > 8'(MaxHeight)) begin
      h_eff = 8'(MaxHeight);
    end else begin
      h_eff = {1'b0, block_height};
    end
  end

  // Pipeline advance: everything moves when the output register frees up.
  logic en;
  logic accept;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && en;

  // Window position counters and line store slot of the current row.
  logic [DimW-1:0] row_count;
  logic [ColW-1:0] col_count;
  logic [2:0]      slot;
  logic [DimW-1:0] r_cur;
  logic [ColW-1:0] c_cur;
  logic [2:0]      slot_cur;
  logic [DimW-1:0] row_count_next;
  logic [ColW-1:0] col_count_next;
  logic [2:0]      slot_next;
  logic            produce_cur;
  logic            last_cur;

  always_comb begin
    r_cur    = window_start ? '0 : row_count;
    c_cur    = window_start ? '0 : col_count;
    slot_cur = window_start ? 3'd0 : slot;
    produce_cur = ({1'b0, r_cur} >= 8'd5) && ({1'b0, r_cur} < h_eff + 8'd5) &&
                  (8'(c_cur) >= 8'd5) && (8'(c_cur) < w_eff + 8'd5);
    last_cur = ({1'b0, r_cur} == h_eff + 8'd4) && (8'(c_cur) == w_eff + 8'd4);
    if (8'(c_cur) >= w_eff + 8'd4) begin
      col_count_next = '0;
      if ({1'b0, r_cur} >= h_eff + 8'd4) begin
        row_count_next = '0;
        slot_next      = 3'd0;
      end else begin
        row_count_next = r_cur + DimW'(1);
        slot_next      = (slot_cur == 3'd4) ? 3'd0 : slot_cur + 3'd1;
      end
    end else begin
      col_count_next = c_cur + ColW'(1);
      row_count_next = r_cur;
      slot_next      = slot_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      slot      <= 3'd0;
    end else if (accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
      slot      <= slot_next;
    end
  end

  // Line store: five banks, one per stored row, read before write.
  logic [PixW-1:0] bank [StoreRows][Depth];
  logic [PixW-1:0] rd [StoreRows];

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int b = 0; b < StoreRows; b++) begin
        rd[b] <= bank[b][c_cur];
        if (slot_cur == 3'(b)) begin
          bank[b][c_cur] <= ref_pixel;
        end
      end
    end
  end

  // Stage 1 registers, alongside the store read.
  logic            s1_valid;
  logic [PixW-1:0] s1_pix;
  logic [2:0]      s1_slot;
  logic            s1_produce;
  logic            s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix     <= ref_pixel;
      s1_slot    <= slot_cur;
      s1_produce <= produce_cur;
      s1_last    <= last_cur;
    end
  end

  // Column of rows r-5..r-1, oldest first.
  logic [PixW-1:0] col [StoreRows];

  always_comb begin
    logic [3:0] idx;
    for (int m = 0; m < StoreRows; m++) begin
      idx = {1'b0, s1_slot} + 4'(m);
      if (idx >= 4'd5) begin
        idx = idx - 4'd5;
      end
      col[m] = rd[idx[2:0]];
    end
  end

  // Vertical 6-tap sum for the current column.
  logic signed [VsumW-1:0] vsum_cur;

  always_comb begin
    logic signed [VsumW-1:0] acc;
    acc = '0;
    for (int m = 0; m < StoreRows; m++) begin
      acc = acc + VsumW'($signed({10'b0, col[m]}) *
                         VsumW'(tap_coef(qpel_y, 3'(m))));
    end
    acc = acc + VsumW'($signed({10'b0, s1_pix}) *
                       VsumW'(tap_coef(qpel_y, 3'd5)));
    vsum_cur = acc;
  end

  // Tap lines: last six vertical sums, last four columns of rows r-4..r-1.
  logic signed [VsumW-1:0] vsum_taps [6];
  logic [PixW-1:0]         pixel_taps [4][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) begin
        vsum_taps[k] <= '0;
      end
      for (int k = 0; k < 4; k++) begin
        for (int m = 0; m < 4; m++) begin
          pixel_taps[k][m] <= '0;
        end
      end
    end else if (en && s1_valid) begin
      for (int k = 0; k < 5; k++) begin
        vsum_taps[k] <= vsum_taps[k+1];
      end
      vsum_taps[5] <= vsum_cur;
      for (int k = 1; k < 4; k++) begin
        pixel_taps[k] <= pixel_taps[k-1];
      end
      for (int m = 0; m < 4; m++) begin
        pixel_taps[0][m] <= col[m+1];
      end
    end
  end

  // Low-pass and copy values from the columns before this one.
  logic [PixW-1:0] lp_val;
  logic [PixW-1:0] copy_val;

  always_comb begin
    logic [11:0] s;
    logic [11:0] rounded;
    s = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        s = s + 12'(pixel_taps[3-j][i]) * 12'(lp_weight(2'(i), 2'(j)));
      end
    end
    rounded  = (s + 12'd8) >> 4;
    lp_val   = rounded[PixW-1:0];
    copy_val = pixel_taps[2][1];
  end

  // Stage 2 registers.
  logic            s2_valid;
  logic            s2_produce;
  logic            s2_last;
  logic [PixW-1:0] s2_lp;
  logic [PixW-1:0] s2_copy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      s2_produce <= s1_produce;
      s2_last    <= s1_last;
      s2_lp      <= lp_val;
      s2_copy    <= copy_val;
    end
  end

  // Horizontal 6-tap filter, rounding and clipping, then mode selection.
  logic [PixW-1:0] result;

  always_comb begin
    logic signed [HsumW-1:0] hs;
    logic signed [HsumW-1:0] shifted;
    hs = '0;
    for (int m = 0; m < 6; m++) begin
      hs = hs + HsumW'(HsumW'(vsum_taps[m]) * HsumW'(tap_coef(qpel_x, 3'(m))));
    end
    hs = hs + HsumW'(RoundOfs);
    shifted = hs >>> RoundShift;
    if (qpel_x == 2'd0 && qpel_y == 2'd0) begin
      result = s2_copy;
    end else if (qpel_x == 2'd2 && qpel_y == 2'd2) begin
      result = s2_lp;
    end else if (hs < 0) begin
      result = '0;
    end else if (shifted > HsumW'(255)) begin
      result = 8'd255;
    end else begin
      result = shifted[PixW-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid && s2_produce;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid && s2_produce) begin
      pred_pixel <= result;
      block_last <= s2_last;
    end
  end

endmodule

>>> verif/luma_quarter_pel_interpolator_tb.sv
`timescale 1ns / 1ps
// Testbench for the luma quarter-pel interpolator: streams reference windows in
// all sixteen fraction modes and checks every predicted pixel against a local model.
// Depends on lqpi_pkg and luma_quarter_pel_interpolator.
module luma_quarter_pel_interpolator_tb;
  import lqpi_pkg::*;

  localparam int Pitch     = MaxWidthDefault + 5;
  localparam int HoldLen   = 200;
  localparam int DrainWait = 8;

  typedef struct packed {
    logic [PixW-1:0] pix;
    logic            last;
  } pred_beat_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [PixW-1:0]      ref_pixel;
  logic                 window_start;
  logic                 out_valid;
  logic                 out_ready;
  logic [PixW-1:0]      pred_pixel;
  logic                 block_last;
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [DimW-1:0]      cfg_data;

  // Local copy of the filter state and registers.
  logic [PixW-1:0] line_store [StoreRows][Pitch];
  int              vsum_line [6];
  int              win_row;
  int              win_col;
  int              cfg_w;
  int              cfg_h;
  int              cfg_hf;
  int              cfg_vf;
  int              six_tap [4][6] = '{'{0, 0, 128, 0, 0, 0},
                                      '{3, -15, 111, 37, -10, 2},
                                      '{3, -17, 78, 78, -17, 3},
                                      '{2, -10, 37, 111, -15, 3}};

  pred_beat_t pred_q[$];
  int         errors;
  bit         no_idle;
  int         hold_reqs;
  int         hold_seen;
  int         hold_left;

  luma_quarter_pel_interpolator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .ref_pixel(ref_pixel), .window_start(window_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .pred_pixel(pred_pixel), .block_last(block_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog against a hung pipeline.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int store_rd(int row, int col);
    if (row < 0 || col < 0 || col >= Pitch) return 0;
    return int'(line_store[row % StoreRows][col]);
  endfunction

  function automatic int clamp_dim(int v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // Advance the local filter by one window pixel; queue a predicted pixel if one is due.
  task automatic predict_pixel(input logic [PixW-1:0] pix, input logic start);
    int w;
    int h;
    int vs;
    int val;
    int s;
    int wt;
    pred_beat_t beat;
    w = clamp_dim(cfg_w, MaxWidthDefault);
    h = clamp_dim(cfg_h, MaxHeight);
    if (start) begin
      win_row = 0;
      win_col = 0;
    end
    vs = six_tap[cfg_vf][5] * int'(pix);
    for (int m = 0; m < 5; m++) vs += six_tap[cfg_vf][m] * store_rd(win_row - 5 + m, win_col);
    for (int m = 0; m < 5; m++) vsum_line[m] = vsum_line[m + 1];
    vsum_line[5] = vs;
    if (win_row >= 5 && win_col >= 5 && win_row - 5 < h && win_col - 5 < w) begin
      if (cfg_hf == 0 && cfg_vf == 0) begin
        val = store_rd(win_row - 3, win_col - 3);
      end else if (cfg_hf == 2 && cfg_vf == 2) begin
        s = 0;
        for (int m = 0; m < 4; m++) begin
          for (int n = 0; n < 4; n++) begin
            wt = ((m == 1 || m == 2) ? 1 : 0) + ((n == 1 || n == 2) ? 1 : 0);
            s += wt * store_rd(win_row - 4 + m, win_col - 4 + n);
          end
        end
        val = (s + 8) >>> 4;
      end else begin
        s = 8192;
        for (int m = 0; m < 6; m++) s += six_tap[cfg_hf][m] * vsum_line[m];
        val = (s < 0) ? 0 : (s >>> 14);
      end
      if (val > 255) val = 255;
      beat.pix  = val[PixW-1:0];
      beat.last = (win_row == h + 4 && win_col == w + 4);
      pred_q.push_back(beat);
    end
    if (win_col < Pitch) line_store[win_row % StoreRows][win_col] = pix;
    if (win_col >= w + 4) begin
      win_col = 0;
      win_row = (win_row >= h + 4) ? 0 : win_row + 1;
    end else begin
      win_col++;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Check each predicted pixel beat and drive the receiver side.
  always @(posedge clk) begin
    pred_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pred_q.size() == 0) begin
        report_mismatch("unexpected beat", int'(pred_pixel), -1);
      end else begin
        want = pred_q.pop_front();
        if (pred_pixel !== want.pix) report_mismatch("pred_pixel", int'(pred_pixel), int'(want.pix));
        if (block_last !== want.last)
          report_mismatch("block_last", int'(block_last), int'(want.last));
      end
    end
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HoldLen;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 31);
    end
  end

  // Offer one window pixel and hold it until taken, then maybe idle.
  task automatic send_pixel(input logic [PixW-1:0] pix, input logic start);
    in_valid     <= 1'b1;
    ref_pixel    <= pix;
    window_start <= start;
    do @(posedge clk); while (!in_ready);
    predict_pixel(pix, start);
    if (!no_idle && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [PixW-1:0] rand_pix();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_pixels(input int count, input bit first_start);
    for (int i = 0; i < count; i++) send_pixel(rand_pix(), first_start && i == 0);
  endtask

  task automatic send_window();
    int cnt;
    cnt = (clamp_dim(cfg_w, MaxWidthDefault) + 5) * (clamp_dim(cfg_h, MaxHeight) + 5);
    send_pixels(cnt, 1'b1);
  endtask

  // Stop offering and wait until every predicted pixel has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pred_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[DimW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BLOCK_WIDTH:  cfg_w  = value & 8'h7F;
      REG_BLOCK_HEIGHT: cfg_h  = value & 8'h7F;
      REG_QPEL_X:       cfg_hf = value & 3;
      default:          cfg_vf = value & 3;
    endcase
  endtask

  // Registers change only once the pipeline is empty.
  task automatic set_frac(input int hf, input int vf);
    drain();
    write_reg(REG_QPEL_X, hf);
    write_reg(REG_QPEL_Y, vf);
  endtask

  task automatic set_block(input int w, input int h, input int hf, input int vf);
    drain();
    write_reg(REG_BLOCK_WIDTH, w);
    write_reg(REG_BLOCK_HEIGHT, h);
    write_reg(REG_QPEL_X, hf);
    write_reg(REG_QPEL_Y, vf);
  endtask

  // The reset configuration is an 8x8 copy; the window is cut after its first output row.
  task automatic test_reset_config();
    send_pixels(6 * (8 + 5), 1'b1);
    drain();
  endtask

  // An oversized width saturates; the one output row walks through every fraction pair.
  task automatic test_all_fractions();
    set_block(127, 1, 0, 0);
    send_pixels(5 * Pitch + 5, 1'b1);
    for (int mode = 0; mode < 16; mode++) begin
      set_frac(mode / 4, mode % 4);
      send_pixels(4, 1'b0);
    end
    drain();
  endtask

  // An oversized height saturates and zero sizes act as 1.
  task automatic test_max_dims();
    set_block(0, 127, $urandom_range(3), $urandom_range(3));
    send_window();
    drain();
    set_block(0, 0, $urandom_range(3), $urandom_range(3));
    send_window();
    drain();
  endtask

  // Restarted windows, wrap without a start flag and a shrink in mid window.
  task automatic test_broken_windows();
    set_block(3, 2, 1, 3);
    send_pixels(20, 1'b1);
    send_window();
    send_pixels((3 + 5) * (2 + 5), 1'b0);
    drain();
    set_block(6, 3, 0, 1);
    send_pixels(30, 1'b1);
    drain();
    set_block(2, 3, 3, 2);
    send_pixels(60, 1'b0);
    drain();
  endtask

  // Stall the output long enough to fill the pipeline, then pause mid window.
  task automatic test_backpressure();
    no_idle = 1'b1;
    set_block(4, 2, 1, 1);
    hold_reqs++;
    send_pixels(56, 1'b1);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pred_q.size() != 0) @(posedge clk);
    send_pixels(7, 1'b0);
    no_idle = 1'b0;
    drain();
  endtask

  // Random configurations of small blocks, some windows cut short.
  task automatic test_random_windows();
    int sent;
    int cnt;
    sent = 0;
    while (sent < 100) begin
      set_block($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(3), $urandom_range(3));
      cnt = (cfg_w + 5) * (cfg_h + 5);
      if ($urandom_range(9) == 0) cnt = $urandom_range(1, cnt - 1);
      send_pixels(cnt, 1'b1);
      sent += cnt;
    end
    drain();
  endtask

  initial begin
    errors       = 0;
    no_idle      = 1'b0;
    hold_reqs    = 0;
    hold_seen    = 0;
    hold_left    = 0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    ref_pixel    = '0;
    window_start = 1'b0;
    out_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_BLOCK_WIDTH;
    cfg_data     = '0;
    cfg_w        = 8;
    cfg_h        = 8;
    cfg_hf       = 0;
    cfg_vf       = 0;
    win_row      = 0;
    win_col      = 0;
    for (int i = 0; i < 6; i++) vsum_line[i] = 0;
    for (int i = 0; i < StoreRows; i++)
      for (int j = 0; j < Pitch; j++) line_store[i][j] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_config();
    test_all_fractions();
    test_broken_windows();
    test_backpressure();
    test_max_dims();
    test_random_windows();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
